/* hw/rtl/cps_pkg.sv */
// ----------------------------------------------------------------------------
// cps_pkg
// Types and constants shared by the cooler power stepper.
// ----------------------------------------------------------------------------
package cps_pkg;

   localparam int TEMP_W  = 14;
   localparam int POWER_W = 8;
   localparam int HOLD_W  = 3;
   localparam int SUSP_W  = 2;
   localparam int CSR_W   = 14;
   localparam int CSR_IDX_W = 2;
   localparam int CALC_W  = 16;

   // bands and slopes in 0.01 C
   localparam logic signed [CALC_W-1:0] NEAR_BAND   = 16'sd200;
   localparam logic signed [CALC_W-1:0] COARSE_BAND = 16'sd70;
   localparam logic signed [CALC_W-1:0] FINE_BAND   = 16'sd20;
   localparam logic signed [CALC_W-1:0] NEAR_SLOPE  = 16'sd3;
   localparam logic signed [CALC_W-1:0] FAR_SLOPE   = 16'sd6;

   localparam logic [POWER_W-1:0] STEP_FAR    = 8'd6;
   localparam logic [POWER_W-1:0] STEP_COARSE = 8'd2;
   localparam logic [POWER_W-1:0] STEP_FINE   = 8'd1;

   localparam logic [HOLD_W-1:0] HOLD_SHORT = 3'd1;
   localparam logic [HOLD_W-1:0] HOLD_MID   = 3'd3;
   localparam logic [HOLD_W-1:0] HOLD_LONG  = 3'd6;

   localparam logic [SUSP_W-1:0] SUSPECT_LIMIT = 2'd3;

   localparam logic [POWER_W-1:0] MAX_POWER_RESET = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_TEMP = 2'd0,
      CSR_MAX_POWER   = 2'd1,
      CSR_AUTO_ENABLE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] target_temp;
      logic [POWER_W-1:0]       max_power;
      logic                     auto_enable;
   } cfg_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] previous_temp;
      logic                     have_reference;
      logic [POWER_W-1:0]       power_now;
      logic [HOLD_W-1:0]        hold_count;
      logic [SUSP_W-1:0]        suspect_count;
   } state_type;

   typedef struct packed {
      logic [POWER_W-1:0] power_level;
      logic               power_write;
      logic [HOLD_W-1:0]  hold_left;
   } result_type;

endpackage

/* hw/rtl/cps_req_if.sv */
// ----------------------------------------------------------------------------
// cps_req_if
// Sample channel: valid/ready with one temperature sample.
// ----------------------------------------------------------------------------
interface cps_req_if import cps_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] sample_temp;
   logic                     sample_valid;

   modport source (output valid, output sample_temp, output sample_valid, input ready);
   modport sink   (input valid, input sample_temp, input sample_valid, output ready);
endinterface

/* hw/rtl/cps_rsp_if.sv */
// ----------------------------------------------------------------------------
// cps_rsp_if
// Result channel: valid/ready with power level, write strobe and hold count.
// ----------------------------------------------------------------------------
interface cps_rsp_if import cps_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [POWER_W-1:0] power_level;
   logic               power_write;
   logic [HOLD_W-1:0]  hold_left;

   modport source (output valid, output power_level, output power_write,
                   output hold_left, input ready);
   modport sink   (input valid, input power_level, input power_write,
                   input hold_left, output ready);
endinterface

/* hw/rtl/cps_csr.sv */
// ----------------------------------------------------------------------------
// cps_csr
// Configuration registers: target temperature, power limit, auto mode.
// ----------------------------------------------------------------------------
module cps_csr import cps_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TARGET_TEMP: cfg_in.target_temp = csr_wdata[TEMP_W-1:0];
            CSR_MAX_POWER:   cfg_in.max_power   = csr_wdata[POWER_W-1:0];
            CSR_AUTO_ENABLE: cfg_in.auto_enable = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_temp <= '0;
         cfg_ff.max_power   <= MAX_POWER_RESET;
         cfg_ff.auto_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/cps_step.sv */
// ----------------------------------------------------------------------------
// cps_step
// One-sample decision: suspect check, band compare, power step and hold.
// ----------------------------------------------------------------------------
module cps_step import cps_pkg::*; (
   input  cfg_type                  cfg,
   input  state_type                state,
   input  logic signed [TEMP_W-1:0] sample_temp,
   input  logic                     sample_valid,
   output state_type                state_next,
   output result_type               result
);

   logic signed [CALC_W-1:0] t_w;
   logic signed [CALC_W-1:0] prev_w;
   logic signed [CALC_W-1:0] tgt_w;
   logic signed [CALC_W-1:0] rise_w;
   logic signed [CALC_W-1:0] fall_w;
   logic signed [CALC_W-1:0] dist_w;
   logic                     do_raise;
   logic                     do_lower;
   logic [POWER_W-1:0]       amount;
   logic [POWER_W:0]         raise_sum;
   logic [POWER_W-1:0]       power_raised;
   logic [POWER_W-1:0]       power_lowered;

   always_comb begin
      t_w    = CALC_W'(sample_temp);
      prev_w = CALC_W'(state.previous_temp);
      tgt_w  = CALC_W'(cfg.target_temp);
      rise_w = t_w - prev_w;
      fall_w = prev_w - t_w;
      dist_w = t_w - tgt_w;
      if (dist_w < 0) begin
         dist_w = -dist_w;
      end
   end

   always_comb begin
      raise_sum = {1'b0, state.power_now} + {1'b0, amount};
      if (raise_sum > {1'b0, cfg.max_power}) begin
         power_raised = cfg.max_power;
      end else begin
         power_raised = raise_sum[POWER_W-1:0];
      end
      if (state.power_now < amount) begin
         power_lowered = '0;
      end else begin
         power_lowered = state.power_now - amount;
      end
   end

   always_comb begin
      state_next = state;
      do_raise   = 1'b0;
      do_lower   = 1'b0;
      amount     = '0;
      if (sample_valid) begin
         state_next.previous_temp  = sample_temp;
         state_next.have_reference = 1'b1;
         if (state.have_reference && cfg.auto_enable) begin
            if (state.hold_count == '0) begin
               if (t_w == prev_w && state.suspect_count < SUSPECT_LIMIT) begin
                  state_next.suspect_count = state.suspect_count + 1'b1;
               end else begin
                  state_next.suspect_count = '0;
                  if (dist_w < NEAR_BAND) begin
                     if (fall_w < NEAR_SLOPE && t_w > tgt_w) begin
                        if (t_w > tgt_w + COARSE_BAND) begin
                           do_raise = 1'b1;
                           amount   = STEP_COARSE;
                           state_next.hold_count = (t_w > prev_w) ? HOLD_MID : HOLD_LONG;
                        end else if (t_w > tgt_w + FINE_BAND) begin
                           do_raise = 1'b1;
                           amount   = STEP_FINE;
                           state_next.hold_count = (t_w > prev_w) ? HOLD_SHORT : HOLD_MID;
                        end
                     end else if (rise_w < NEAR_SLOPE && t_w < tgt_w) begin
                        if (t_w < tgt_w - COARSE_BAND) begin
                           do_lower = 1'b1;
                           amount   = STEP_COARSE;
                           state_next.hold_count = (t_w < prev_w) ? HOLD_MID : HOLD_LONG;
                        end else if (t_w < tgt_w - FINE_BAND) begin
                           do_lower = 1'b1;
                           amount   = STEP_FINE;
                           state_next.hold_count = (t_w < prev_w) ? HOLD_SHORT : HOLD_MID;
                        end
                     end
                  end else if (tgt_w < t_w) begin
                     if (fall_w < FAR_SLOPE) begin
                        do_raise = 1'b1;
                        amount   = STEP_FAR;
                        state_next.hold_count = (t_w > prev_w) ? HOLD_SHORT : HOLD_MID;
                     end
                  end else begin
                     if (rise_w < FAR_SLOPE) begin
                        do_lower = 1'b1;
                        amount   = STEP_FAR;
                        state_next.hold_count = (t_w < prev_w) ? HOLD_SHORT : HOLD_MID;
                     end
                  end
               end
            end else begin
               state_next.hold_count = state.hold_count - 1'b1;
            end
         end
      end
      if (do_raise) begin
         state_next.power_now = power_raised;
      end else if (do_lower) begin
         state_next.power_now = power_lowered;
      end
      result.power_level = state_next.power_now;
      result.power_write = do_raise | do_lower;
      result.hold_left   = state_next.hold_count;
   end

endmodule

/* hw/rtl/cooler_power_stepper.sv */
// ----------------------------------------------------------------------------
// cooler_power_stepper
// Steps cooler power from a stream of temperature samples toward a target.
//
//   channel  direction  handshake      payload
//   req_if   in         valid/ready    sample_temp, sample_valid
//   rsp_if   out        valid/ready    power_level, power_write, hold_left
//   csr_*    in         write enable   index, data (no read-back)
//
// One sample per cycle while rsp_if is not stalled. A sample transferred on req_if
// passes an input register, the decision logic and a result register to rsp_if.
// Synchronous reset clears state, both stage valids and loads register resets.
// A stalled rsp_if holds the result; req_if still takes one more sample into
// the input register if that is empty, then stalls until the result transfers.
// ----------------------------------------------------------------------------
module cooler_power_stepper import cps_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   cps_req_if.sink              req_if,
   cps_rsp_if.source            rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   cfg_type                  cfg;
   state_type                state_ff;
   state_type                state_in;
   result_type               result_in;
   result_type               rsp_ff;
   logic                     in_valid_ff;
   logic                     out_valid_ff;
   logic signed [TEMP_W-1:0] temp_ff;
   logic                     sample_valid_ff;
   logic                     advance;

   cps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cps_step u_step (
      .cfg          (cfg),
      .state        (state_ff),
      .sample_temp  (temp_ff),
      .sample_valid (sample_valid_ff),
      .state_next   (state_in),
      .result       (result_in)
   );

   assign advance       = !out_valid_ff || rsp_if.ready;
   assign req_if.ready  = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         temp_ff         <= req_if.sample_temp;
         sample_valid_ff <= req_if.sample_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff && advance) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.power_level = rsp_ff.power_level;
   assign rsp_if.power_write = rsp_ff.power_write;
   assign rsp_if.hold_left   = rsp_ff.hold_left;

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_if.ready |=> $stable(state_ff))
      else $error("state changed while result stalled");

   a_write_starts_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_ff.power_write |-> rsp_ff.hold_left != '0)
      else $error("power write without hold");

   a_no_ref_idle: assert property (@(posedge clock) disable iff (reset)
      !state_ff.have_reference |->
         state_ff.power_now == '0 && state_ff.hold_count == '0 &&
         state_ff.suspect_count == '0)
      else $error("state moved before reference seeded");

   a_hold_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.hold_count <= HOLD_LONG)
      else $error("hold count out of range");

endmodule

/* test/cooler_power_stepper_tb.sv */
// ----------------------------------------------------------------------------
// cooler_power_stepper_tb
// Self-checking bench for the cooler power stepper. A built-in predictor
// tracks power, hold and suspect state per accepted sample. Directed runs
// cover seeding, invalid samples, unchanged readings, the bands, the zero
// floor and disabled auto mode. Random temperature walks around changing
// targets follow under several idle and stall mixes, with a backpressure run.
// ----------------------------------------------------------------------------
module cooler_power_stepper_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cps_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int TEMP_MIN        = -5000;
   localparam int TEMP_MAX        = 5000;
   localparam int BLOCKS_PER_PHASE = 8;
   localparam int ITEMS_PER_BLOCK = 58;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   cps_req_if req_if ();
   cps_rsp_if rsp_if ();

   cooler_power_stepper u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of registers and state
   int         set_target;
   int         set_max_power;
   bit         set_auto;
   int         last_temp;
   bit         seeded;
   int         power_lvl;
   int         hold_cnt;
   int         suspect_cnt;

   result_type pending_results[$];
   int         mismatch_count;
   int         idle_cycles;
   int         send_idle_pct;
   int         stall_pct;
   int         hold_off_req;
   int         hold_off_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int clamp_temp(int v);
      if (v < TEMP_MIN) return TEMP_MIN;
      if (v > TEMP_MAX) return TEMP_MAX;
      return v;
   endfunction

   function automatic void raise_power(int amount);
      power_lvl = (power_lvl + amount > set_max_power) ? set_max_power : power_lvl + amount;
   endfunction

   function automatic void lower_power(int amount);
      power_lvl = (power_lvl - amount < 0) ? 0 : power_lvl - amount;
   endfunction

   function automatic void apply_correction(int t);
      int gap;
      gap = t - set_target;
      if (gap < 0) gap = -gap;
      if (t == last_temp && suspect_cnt < int'(SUSPECT_LIMIT)) begin
         suspect_cnt++;
      end else if (gap < int'(NEAR_BAND)) begin
         suspect_cnt = 0;
         if (last_temp - t < int'(NEAR_SLOPE) && t > set_target) begin
            if (t > set_target + int'(COARSE_BAND)) begin
               raise_power(int'(STEP_COARSE));
               hold_cnt = (t > last_temp) ? int'(HOLD_MID) : int'(HOLD_LONG);
            end else if (t > set_target + int'(FINE_BAND)) begin
               raise_power(int'(STEP_FINE));
               hold_cnt = (t > last_temp) ? int'(HOLD_SHORT) : int'(HOLD_MID);
            end
         end else if (t - last_temp < int'(NEAR_SLOPE) && t < set_target) begin
            if (t < set_target - int'(COARSE_BAND)) begin
               lower_power(int'(STEP_COARSE));
               hold_cnt = (t < last_temp) ? int'(HOLD_MID) : int'(HOLD_LONG);
            end else if (t < set_target - int'(FINE_BAND)) begin
               lower_power(int'(STEP_FINE));
               hold_cnt = (t < last_temp) ? int'(HOLD_SHORT) : int'(HOLD_MID);
            end
         end
      end else if (set_target < t) begin
         suspect_cnt = 0;
         if (last_temp - t < int'(FAR_SLOPE)) begin
            raise_power(int'(STEP_FAR));
            hold_cnt = (t > last_temp) ? int'(HOLD_SHORT) : int'(HOLD_MID);
         end
      end else if (set_target > t) begin
         suspect_cnt = 0;
         if (t - last_temp < int'(FAR_SLOPE)) begin
            lower_power(int'(STEP_FAR));
            hold_cnt = (t < last_temp) ? int'(HOLD_SHORT) : int'(HOLD_MID);
         end
      end
   endfunction

   function automatic result_type next_cooler_result(int t, bit sample_ok);
      result_type r;
      bit         wrote;
      wrote = 1'b0;
      if (sample_ok) begin
         if (!seeded) begin
            seeded = 1'b1;
         end else if (set_auto) begin
            if (hold_cnt == 0) begin
               apply_correction(t);
               wrote = (hold_cnt != 0);
            end else begin
               hold_cnt--;
            end
         end
         last_temp = t;
      end
      r.power_level = power_lvl[POWER_W-1:0];
      r.power_write = wrote;
      r.hold_left   = hold_cnt[HOLD_W-1:0];
      return r;
   endfunction

   // transfer monitor, result checker and watchdog
   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            pending_results.push_back(next_cooler_result(int'(req_if.sample_temp),
                                                         req_if.sample_valid));
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
               mismatch_count++;
               $display("%0t unexpected result: power_level %0d power_write %0d hold_left %0d",
                        $time, rsp_if.power_level, rsp_if.power_write, rsp_if.hold_left);
            end else begin
               want = pending_results.pop_front();
               if (rsp_if.power_level !== want.power_level) begin
                  mismatch_count++;
                  $display("%0t power_level mismatch: expected %0d actual %0d",
                           $time, want.power_level, rsp_if.power_level);
               end
               if (rsp_if.power_write !== want.power_write) begin
                  mismatch_count++;
                  $display("%0t power_write mismatch: expected %0d actual %0d",
                           $time, want.power_write, rsp_if.power_write);
               end
               if (rsp_if.hold_left !== want.hold_left) begin
                  mismatch_count++;
                  $display("%0t hold_left mismatch: expected %0d actual %0d",
                           $time, want.hold_left, rsp_if.hold_left);
               end
            end
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
            $display("status: fail");
            $finish;
         end
      end
   end

   // result side: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (hold_off_req > 0) begin
         hold_off_left = hold_off_req;
         hold_off_req  = 0;
      end
      if (hold_off_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_off_left--;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic send_sample(int t, bit ok);
      req_if.valid        <= 1'b1;
      req_if.sample_temp  <= TEMP_W'(t);
      req_if.sample_valid <= ok;
      do @(posedge clock); while (!req_if.ready);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic wait_results_done();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(int target, int max_pw, bit auto_on);
      csr_we    <= 1'b1;
      csr_index <= CSR_TARGET_TEMP;
      csr_wdata <= CSR_W'(target);
      @(posedge clock);
      csr_index <= CSR_MAX_POWER;
      csr_wdata <= CSR_W'(max_pw);
      @(posedge clock);
      csr_index <= CSR_AUTO_ENABLE;
      csr_wdata <= CSR_W'(auto_on);
      @(posedge clock);
      csr_we        <= 1'b0;
      set_target    = target;
      set_max_power = max_pw;
      set_auto      = auto_on;
   endtask

   // reset values, auto off: invalid before seeding, seed, then tracking only
   task automatic test_first_sample();
      send_sample(0, 1'b0);
      send_sample(TEMP_MIN, 1'b1);
      send_sample(TEMP_MAX, 1'b1);
   endtask

   // three suspect repeats, then a far step up and its hold
   task automatic test_unchanged_reading();
      int temps[7] = '{TEMP_MAX, TEMP_MAX, TEMP_MAX, TEMP_MAX, 141, 141, 141};
      wait_results_done();
      set_config(0, 255, 1'b1);
      foreach (temps[i]) send_sample(temps[i], 1'b1);
   endtask

   // moving the right way, coarse up, fine down, far down, coarse down to zero
   task automatic test_near_bands();
      int temps[10] = '{130, 131, -31, -31, -31, -32, -2000, -2001, -100, -101};
      foreach (temps[i]) send_sample(temps[i], 1'b1);
   endtask

   // power already at zero: step changes nothing but the hold still starts
   task automatic test_power_floor();
      int temps[4] = '{-101, -101, -101, -102};
      foreach (temps[i]) send_sample(temps[i], 1'b1);
   endtask

   // hold frozen while auto is off
   task automatic test_auto_disabled();
      wait_results_done();
      set_config(0, 255, 1'b0);
      send_sample(-90, 1'b1);
      send_sample(TEMP_MIN, 1'b1);
   endtask

   // long result stall fills the pipe, then the sender waits for the drain
   task automatic test_backpressure();
      wait_results_done();
      set_config(0, 40, 1'b1);
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_off_req  = 60;
      repeat (12) send_sample(int'($urandom_range(0, 600)) - 300, 1'b1);
      wait_results_done();
   endtask

   task automatic test_random_phase(int sender_pct, int recv_pct);
      int temp;
      int target;
      int max_pw;
      bit auto_on;
      int r;
      send_idle_pct = sender_pct;
      stall_pct     = recv_pct;
      for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
         wait_results_done();
         case (blk % 4)
            0: begin
               target = TEMP_MIN;
               max_pw = 0;
            end
            1: begin
               target = TEMP_MAX;
               max_pw = 255;
            end
            default: begin
               target = int'($urandom_range(0, 10000)) - 5000;
               max_pw = $urandom_range(0, 255);
            end
         endcase
         auto_on = ($urandom_range(0, 9) != 0);
         set_config(target, max_pw, auto_on);
         temp = clamp_temp(target + int'($urandom_range(0, 800)) - 400);
         repeat (ITEMS_PER_BLOCK) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
               send_sample(int'($urandom_range(0, 10000)) - 5000, 1'b0);
            end else if (r < 8) begin
               temp = int'($urandom_range(0, 10000)) - 5000;
               send_sample(temp, 1'b1);
            end else if (r < 28) begin
               send_sample(temp, 1'b1);
            end else begin
               temp = clamp_temp(temp + int'($urandom_range(0, 16)) - 8);
               send_sample(temp, 1'b1);
            end
         end
      end
   endtask

   initial begin
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.sample_temp  = '0;
      req_if.sample_valid = 1'b0;
      rsp_if.ready        = 1'b0;
      csr_we              = 1'b0;
      csr_index           = CSR_TARGET_TEMP;
      csr_wdata           = '0;
      set_target          = 0;
      set_max_power       = int'(MAX_POWER_RESET);
      set_auto            = 1'b0;
      last_temp           = 0;
      seeded              = 1'b0;
      power_lvl           = 0;
      hold_cnt            = 0;
      suspect_cnt         = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_first_sample();
      test_unchanged_reading();
      test_near_bands();
      test_power_floor();
      test_auto_disabled();
      test_backpressure();
      test_random_phase(0, 0);
      test_random_phase(69, 0);
      test_random_phase(0, 69);
      test_random_phase(32, 32);
      wait_results_done();

      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/cps_pkg.sv
hw/rtl/cps_req_if.sv
hw/rtl/cps_rsp_if.sv
hw/rtl/cps_csr.sv
hw/rtl/cps_step.sv
hw/rtl/cooler_power_stepper.sv
test/cooler_power_stepper_tb.sv
